[hw/rtl/line_clip_to_image_defines.svh]
// Assertion macros shared by the line clipper checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef LINE_CLIP_TO_IMAGE_DEFINES_SVH
`define LINE_CLIP_TO_IMAGE_DEFINES_SVH

// Same-cycle implication, disabled in reset
`define LCTI_ASSERT_NOW(lbl, ck, rstn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("line clip check failed");

// Next-cycle implication, disabled in reset
`define LCTI_ASSERT_NEXT(lbl, ck, rstn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("line clip check failed");

`endif

[hw/rtl/lcti_pkg.sv]
// Shared types, constants and lane setup for the line clipper.
// No dependencies; used by the top level, front end, divider step and pick modules.
`timescale 1ns / 1ps

package lcti_pkg;

    localparam int QW    = 13;  // quotient bits, covers limits up to 8191
    localparam int CFG_W = 13;  // width of the size registers
    localparam int REM_W = 46;  // divider remainder
    localparam int NUM_W = 47;  // signed numerator before sign fix

    // register indexes (paddr[2])
    localparam logic REG_IMG_WIDTH  = 1'b0;
    localparam logic REG_IMG_HEIGHT = 1'b1;

    // one border candidate traveling through the divider
    typedef struct packed {
        logic             ok;
        logic [REM_W-1:0] rem;
        logic [31:0]      den;
        logic [QW-1:0]    q;
    } lane_t;

    typedef lane_t [3:0] lane_vec_t;

    // Normalize to a positive divisor and run the keep test 0 <= n/d < lim
    function automatic lane_t lane_prep(
        input logic signed [NUM_W-1:0] n,
        input logic signed [31:0]      d,
        input logic signed [NUM_W-1:0] limd,
        input logic                    en
    );
        lane_t                   r;
        logic signed [NUM_W-1:0] nn;
        logic signed [NUM_W-1:0] ll;
        logic signed [32:0]      dd;
        dd    = d[31] ? -(33'(d)) : 33'(d);
        nn    = d[31] ? -n : n;
        ll    = d[31] ? -limd : limd;
        r.ok  = en && (d != 32'sd0) && !nn[NUM_W-1] && (nn < ll);
        r.rem = nn[REM_W-1:0];
        r.den = dd[31:0];
        r.q   = '0;
        return r;
    endfunction

endpackage

[hw/rtl/lcti_front.sv]
// Front end: border products, numerators and keep tests (two stages).
// Depends on lcti_pkg.
`timescale 1ns / 1ps

module lcti_front
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en_a,
    input  logic                        en_b,
    input  logic                        in_valid,
    input  logic [95:0]                 in_data,
    input  logic [lcti_pkg::CFG_W-1:0]  img_w,
    input  logic [lcti_pkg::CFG_W-1:0]  img_h,
    output logic                        valid_a,
    output logic                        valid_b,
    output lcti_pkg::lane_vec_t         lanes
);

    logic               va_reg, vb_reg;
    logic signed [31:0] a_reg, b_reg, c_reg;
    logic signed [45:0] pa_reg, pb_reg, lbh_reg, law_reg;
    logic signed [31:0] a_in, b_in, c_in;
    logic signed [13:0] wm1, hm1, wl, hl;
    lcti_pkg::lane_vec_t lanes_next, lanes_reg;
    logic signed [lcti_pkg::NUM_W-1:0] nc, n1, n3;

    assign a_in = in_data[31:0];
    assign b_in = in_data[63:32];
    assign c_in = in_data[95:64];
    assign wm1  = $signed({1'b0, img_w - 13'd1});
    assign hm1  = $signed({1'b0, img_h - 13'd1});
    assign wl   = $signed({1'b0, img_w});
    assign hl   = $signed({1'b0, img_h});

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else
        begin
            if (en_a)
                va_reg <= in_valid;
            if (en_b)
                vb_reg <= va_reg;
        end
    end

    // stage A: products against the border positions and limits
    always_ff @(posedge clk)
    begin
        if (en_a)
        begin
            a_reg   <= a_in;
            b_reg   <= b_in;
            c_reg   <= c_in;
            pa_reg  <= a_in * wm1;
            pb_reg  <= b_in * hm1;
            lbh_reg <= b_in * hl;
            law_reg <= a_in * wl;
        end
    end

    // stage B: numerators, sign fix and keep test per candidate
    always_comb
    begin
        nc = -(lcti_pkg::NUM_W'(c_reg));
        n1 = nc - lcti_pkg::NUM_W'(pa_reg);
        n3 = nc - lcti_pkg::NUM_W'(pb_reg);
        lanes_next[0] = lcti_pkg::lane_prep(nc, b_reg, lcti_pkg::NUM_W'(lbh_reg),
                                            img_w != '0);
        lanes_next[1] = lcti_pkg::lane_prep(n1, b_reg, lcti_pkg::NUM_W'(lbh_reg),
                                            img_w != '0);
        lanes_next[2] = lcti_pkg::lane_prep(nc, a_reg, lcti_pkg::NUM_W'(law_reg),
                                            img_h != '0);
        lanes_next[3] = lcti_pkg::lane_prep(n3, a_reg, lcti_pkg::NUM_W'(law_reg),
                                            img_h != '0);
    end

    always_ff @(posedge clk)
    begin
        if (en_b)
            lanes_reg <= lanes_next;
    end

    assign valid_a = va_reg;
    assign valid_b = vb_reg;
    assign lanes   = lanes_reg;

endmodule

[hw/rtl/lcti_div_step.sv]
// One restoring-division step, one quotient bit for all four candidates.
// Depends on lcti_pkg.
`timescale 1ns / 1ps

module lcti_div_step
#(
    parameter int BIT = 0
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  lcti_pkg::lane_vec_t in_lanes,
    output logic                out_valid,
    output lcti_pkg::lane_vec_t out_lanes
);

    logic                v_reg;
    lcti_pkg::lane_vec_t lanes_next, lanes_reg;
    logic [lcti_pkg::REM_W-1:0] trial [4];

    // compare and subtract the shifted divisor
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            lanes_next[i] = in_lanes[i];
            trial[i] = lcti_pkg::REM_W'(in_lanes[i].den) << BIT;
            if (in_lanes[i].rem >= trial[i])
            begin
                lanes_next[i].rem    = in_lanes[i].rem - trial[i];
                lanes_next[i].q[BIT] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (en)
            v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            lanes_reg <= lanes_next;
    end

    assign out_valid = v_reg;
    assign out_lanes = lanes_reg;

endmodule

[hw/rtl/lcti_pick.sv]
// Picks the first two kept candidates and registers the result beat.
// Depends on lcti_pkg.
`timescale 1ns / 1ps

module lcti_pick
#(
    parameter int COORD_BITS = 12
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  lcti_pkg::lane_vec_t        in_lanes,
    input  logic [lcti_pkg::CFG_W-1:0] img_w,
    input  logic [lcti_pkg::CFG_W-1:0] img_h,
    output logic                       out_valid,
    output logic [((1 + 4*COORD_BITS + 7) / 8) * 8 - 1:0] out_data
);

    localparam int TDW = ((1 + 4*COORD_BITS + 7) / 8) * 8;

    logic                      v_reg;
    logic [TDW-1:0]            data_reg, data_next;
    logic [lcti_pkg::QW-1:0]   px [4];
    logic [lcti_pkg::QW-1:0]   py [4];
    logic [1:0]                first, second;
    logic [2:0]                cnt;
    logic [31:0]               sx, sy, ex, ey;
    logic [lcti_pkg::CFG_W-1:0] wm1, hm1;

    assign wm1 = img_w - 13'd1;
    assign hm1 = img_h - 13'd1;

    // candidate points in border order
    always_comb
    begin
        px[0] = '0;
        py[0] = in_lanes[0].q;
        px[1] = wm1;
        py[1] = in_lanes[1].q;
        px[2] = in_lanes[2].q;
        py[2] = '0;
        px[3] = in_lanes[3].q;
        py[3] = hm1;
    end

    // first two kept candidates
    always_comb
    begin
        first  = 2'd0;
        second = 2'd0;
        cnt    = 3'd0;
        for (int i = 0; i < 4; i++)
        begin
            if (in_lanes[i].ok)
            begin
                if (cnt == 3'd0)
                    first = 2'(i);
                else if (cnt == 3'd1)
                    second = 2'(i);
                cnt = cnt + 3'd1;
            end
        end
        sx = 32'(px[first]);
        sy = 32'(py[first]);
        ex = 32'(px[second]);
        ey = 32'(py[second]);
        data_next = '0;
        if (cnt >= 3'd2)
            data_next[4*COORD_BITS:0] = {ey[COORD_BITS-1:0], ex[COORD_BITS-1:0],
                                         sy[COORD_BITS-1:0], sx[COORD_BITS-1:0], 1'b1};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (en)
            v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign out_valid = v_reg;
    assign out_data  = data_reg;

endmodule

[hw/rtl/line_clip_to_image.sv]
// Top level of the line clipper: stream ports, size registers, pipeline.
// Depends on lcti_pkg, lcti_front, lcti_div_step and lcti_pick.
`timescale 1ns / 1ps

// Clips a line a*x+b*y+c=0 (signed Q16.16) to the image rectangle and returns the
// first two border crossings (left, right, top, bottom order) in whole pixels.
// One line is taken per clock while no stall holds the pipeline; each beat passes through
// two front stages (products, then numerators and keep tests), a 13-stage
// restoring divider giving one quotient bit per stage, and the output register.
// A stall reaches s_tready in the same cycle; only full stages hold, so bubbles
// are squeezed out. img_width and img_height are written over APB and must stay
// put while lines are in flight.

module line_clip_to_image
#(
    parameter int COORD_BITS = 12
)
(
    input  logic        clk,
    input  logic        rst_n,
    // slave stream: [31:0] line_a, [63:32] line_b, [95:64] line_c
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,
    // master stream: [0] found, then start_x, start_y, end_x, end_y, zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [((1 + 4*COORD_BITS + 7) / 8) * 8 - 1:0] m_tdata,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int QW  = lcti_pkg::QW;
    localparam int NST = QW + 3;

    logic [lcti_pkg::CFG_W-1:0] img_w_reg, img_h_reg;
    logic [NST-1:0]             v;
    logic [NST-1:0]             en;
    lcti_pkg::lane_vec_t        lanes [QW+1];

    // size registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            img_w_reg <= 13'd640;
            img_h_reg <= 13'd480;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[2])
                lcti_pkg::REG_IMG_WIDTH:  img_w_reg <= pwdata[12:0];
                lcti_pkg::REG_IMG_HEIGHT: img_h_reg <= pwdata[12:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            lcti_pkg::REG_IMG_WIDTH:  prdata = 32'(img_w_reg);
            lcti_pkg::REG_IMG_HEIGHT: prdata = 32'(img_h_reg);
            default:                  prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // a stage advances when it is empty or the stage after it advances
    always_comb
    begin
        en[NST-1] = !v[NST-1] || m_tready;
        for (int k = NST-2; k >= 0; k--)
            en[k] = !v[k] || en[k+1];
    end

    assign s_tready = en[0];

    lcti_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en_a     (en[0]),
        .en_b     (en[1]),
        .in_valid (s_tvalid),
        .in_data  (s_tdata),
        .img_w    (img_w_reg),
        .img_h    (img_h_reg),
        .valid_a  (v[0]),
        .valid_b  (v[1]),
        .lanes    (lanes[0])
    );

    for (genvar g = 0; g < QW; g++)
    begin : g_div
        lcti_div_step #(.BIT(QW-1-g)) u_step
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en[g+2]),
            .in_valid  (v[g+1]),
            .in_lanes  (lanes[g]),
            .out_valid (v[g+2]),
            .out_lanes (lanes[g+1])
        );
    end

    lcti_pick #(.COORD_BITS(COORD_BITS)) u_pick
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en[NST-1]),
        .in_valid  (v[NST-2]),
        .in_lanes  (lanes[QW]),
        .img_w     (img_w_reg),
        .img_h     (img_h_reg),
        .out_valid (v[NST-1]),
        .out_data  (m_tdata)
    );

    assign m_tvalid = v[NST-1];

endmodule

[hw/rtl/lcti_sva.sv]
// Port-level checks for the line clipper, bound to the top level.
// Depends on line_clip_to_image_defines.svh and line_clip_to_image.
`timescale 1ns / 1ps
`include "line_clip_to_image_defines.svh"

module lcti_sva
#(
    parameter int COORD_BITS = 12
)
(
    input logic clk,
    input logic rst_n,
    input logic s_tvalid,
    input logic s_tready,
    input logic m_tvalid,
    input logic m_tready,
    input logic [((1 + 4*COORD_BITS + 7) / 8) * 8 - 1:0] m_tdata,
    input logic pready
);

    localparam int TDW = ((1 + 4*COORD_BITS + 7) / 8) * 8;

    // a stalled result beat holds
    `LCTI_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    // a miss carries all-zero coordinates
    `LCTI_ASSERT_NOW(a_miss_zero, clk, rst_n, m_tvalid && !m_tdata[0], m_tdata[TDW-1:1] == '0)
    // an open output keeps the input side open
    `LCTI_ASSERT_NOW(a_no_block, clk, rst_n, !m_tvalid, s_tready)
    // config port never waits
    `LCTI_ASSERT_NOW(a_pready, clk, rst_n, 1'b1, pready)

endmodule

bind line_clip_to_image lcti_sva #(.COORD_BITS(COORD_BITS)) u_lcti_sva
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .pready   (pready)
);
